// ===== rtl/script_tokenizer_defines.svh =====
// Assertion macros used by the script tokenizer RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SCRIPT_TOKENIZER_DEFINES_SVH
`define SCRIPT_TOKENIZER_DEFINES_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent holds.
`define STC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("script_tokenizer: same-cycle check failed");

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define STC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("script_tokenizer: next-cycle check failed");

`endif

// ===== rtl/stc_pkg.sv =====
// Shared types, constants and character-class helpers for the script tokenizer.
// No dependencies; imported by every RTL module of the block.
package stc_pkg;

    // Limits.
    localparam logic [15:0] MAX_TOKENS = 16'd512;
    localparam logic [7:0]  MAX_TEXT   = 8'd62;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // Operator codes for the two-character operators.
    localparam logic [7:0] OP_EQ = 8'h45;  // ==
    localparam logic [7:0] OP_NE = 8'h4E;  // !=
    localparam logic [7:0] OP_LE = 8'h4C;  // <=
    localparam logic [7:0] OP_GE = 8'h47;  // >=

    // Lexer modes.
    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_COMMENT = 3'd1,
        M_NUMBER  = 3'd2,
        M_STRING  = 3'd3,
        M_IDENT   = 3'd4,
        M_HELD    = 3'd5,
        M_DISCARD = 3'd6,
        M_ENDING  = 3'd7
    } t_mode;

    // Result kinds.
    typedef enum logic [2:0] {
        K_NUM  = 3'd0,
        K_SCHR = 3'd1,
        K_ICHR = 3'd2,
        K_SEND = 3'd3,
        K_IEND = 3'd4,
        K_OP   = 3'd5,
        K_END  = 3'd6,
        K_ERR  = 3'd7
    } t_kind;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [15:0] line;
        logic        last;
    } t_result;

    // Up to two results produced by one source byte.
    typedef struct packed {
        logic [1:0] count;
        t_result    res1;
        t_result    res0;
    } t_push;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == 8'h5F);
    endfunction

    // Single-character operators: ; ( ) { } , + - * / %
    function automatic logic is_single_op(input logic [7:0] c);
        return (c == 8'h3B) || (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) ||
               (c == 8'h7D) || (c == 8'h2C) || (c == 8'h2B) || (c == 8'h2D) ||
               (c == 8'h2A) || (c == 8'h2F) || (c == 8'h25);
    endfunction

    // Appends a result to a pair; a third result is dropped.
    function automatic t_push push_res(input t_push p, input t_kind k,
                                       input logic [63:0] v, input logic [15:0] ln);
        t_push   q;
        t_result r;
        q       = p;
        r.kind  = k;
        r.value = v;
        r.line  = ln;
        r.last  = 1'b0;
        if (p.count == 2'd0) begin
            q.res0  = r;
            q.count = 2'd1;
        end else if (p.count == 2'd1) begin
            q.res1  = r;
            q.count = 2'd2;
        end
        return q;
    endfunction

endpackage

// ===== rtl/stc_lexer.sv =====
// Lexer state machine: turns one accepted source byte into up to two results.
// Depends on stc_pkg for modes, kinds, limits and character classes.
module stc_lexer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_char,
    output stc_pkg::t_push o_push
);
    import stc_pkg::*;

    t_mode       r_mode,  n_mode;
    logic [63:0] r_acc,   n_acc;
    logic [7:0]  r_tcnt,  n_tcnt;
    logic [7:0]  r_held,  n_held;
    logic [15:0] r_line,  n_line;
    logic [15:0] r_tok,   n_tok;
    t_push       s_push;

    // Lexer state registers, updated once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= '0;
            r_tcnt <= '0;
            r_held <= '0;
            r_line <= 16'd1;
            r_tok  <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_tcnt <= n_tcnt;
            r_held <= n_held;
            r_line <= n_line;
            r_tok  <= n_tok;
        end
    end

    // Next state and results for the byte on i_char.
    always_comb begin : p_step
        logic [7:0]  c;
        logic        do_td1;
        logic        td1_idle;
        logic        do_idle;
        logic        do_td2;
        logic        do_restart;
        logic        lim;
        logic [7:0]  h;
        logic [7:0]  op;
        logic [63:0] digit;

        c          = i_char;
        n_mode     = r_mode;
        n_acc      = r_acc;
        n_tcnt     = r_tcnt;
        n_held     = r_held;
        n_line     = r_line;
        n_tok      = r_tok;
        s_push     = '0;
        do_td1     = 1'b0;
        td1_idle   = 1'b0;
        do_idle    = 1'b0;
        do_td2     = 1'b0;
        do_restart = 1'b0;
        lim        = 1'b0;
        h          = r_held;
        op         = '0;
        digit      = {56'd0, c - CH_ZERO};

        // Mode-specific handling of the byte.
        unique case (r_mode)
            M_DISCARD: begin
                if (c == CH_NUL) do_restart = 1'b1;
            end
            M_ENDING: begin
                s_push = push_res(s_push, K_END, 64'd0, r_line);
                n_mode = M_DISCARD;
                if (c == CH_NUL) do_restart = 1'b1;
            end
            M_COMMENT: begin
                if ((c == CH_NUL) || (c == CH_LF)) do_idle = 1'b1;
            end
            M_NUMBER: begin
                if (is_digit(c)) begin
                    n_acc = (r_acc << 3) + (r_acc << 1) + digit;
                end else begin
                    s_push   = push_res(s_push, K_NUM, r_acc, r_line);
                    n_acc    = '0;
                    do_td1   = 1'b1;
                    td1_idle = 1'b1;
                end
            end
            M_STRING: begin
                if (c == CH_QUOTE) begin
                    s_push = push_res(s_push, K_SEND, 64'd0, r_line);
                    n_mode = M_IDLE;
                    do_td1 = 1'b1;
                end else if ((c == CH_NUL) || (r_tcnt >= MAX_TEXT)) begin
                    s_push   = push_res(s_push, K_SEND, 64'd0, r_line);
                    n_mode   = M_IDLE;
                    do_td1   = 1'b1;
                    td1_idle = 1'b1;
                end else begin
                    s_push = push_res(s_push, K_SCHR, {56'd0, c}, r_line);
                    n_tcnt = r_tcnt + 8'd1;
                end
            end
            M_IDENT: begin
                if ((is_alpha(c) || is_digit(c)) && (r_tcnt < MAX_TEXT)) begin
                    s_push = push_res(s_push, K_ICHR, {56'd0, c}, r_line);
                    n_tcnt = r_tcnt + 8'd1;
                end else begin
                    s_push   = push_res(s_push, K_IEND, 64'd0, r_line);
                    n_mode   = M_IDLE;
                    do_td1   = 1'b1;
                    td1_idle = 1'b1;
                end
            end
            M_HELD: begin
                n_held = '0;
                n_mode = M_IDLE;
                if (c == CH_EQ) begin
                    if (h == CH_EQ)        op = OP_EQ;
                    else if (h == CH_BANG) op = OP_NE;
                    else if (h == CH_LT)   op = OP_LE;
                    else                   op = OP_GE;
                    s_push = push_res(s_push, K_OP, {56'd0, op}, r_line);
                    do_td1 = 1'b1;
                end else if (h == CH_BANG) begin
                    s_push = push_res(s_push, K_ERR, {56'd0, CH_BANG}, r_line);
                    n_mode = M_DISCARD;
                    if (c == CH_NUL) do_restart = 1'b1;
                end else begin
                    s_push   = push_res(s_push, K_OP, {56'd0, h}, r_line);
                    do_td1   = 1'b1;
                    td1_idle = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // Token completed by the mode handling; the limit may stop the byte here.
        if (do_td1) begin
            n_tok = n_tok + 16'd1;
            lim   = (n_tok >= MAX_TOKENS);
            if (lim) begin
                if (s_push.count != 2'd2) begin
                    s_push = push_res(s_push, K_END, 64'd0, r_line);
                    n_mode = M_DISCARD;
                    if (c == CH_NUL) do_restart = 1'b1;
                end else begin
                    n_mode = M_ENDING;
                end
            end else if (td1_idle) begin
                do_idle = 1'b1;
            end
        end

        // Fresh tokenizing of the byte from the idle mode.
        if (do_idle) begin
            n_mode = M_IDLE;
            if (c == CH_NUL) begin
                s_push     = push_res(s_push, K_END, 64'd0, r_line);
                do_restart = 1'b1;
            end else if (c == CH_LF) begin
                if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
            end else if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR)) begin
                n_mode = M_IDLE;
            end else if (c == CH_HASH) begin
                n_mode = M_COMMENT;
            end else if (is_digit(c)) begin
                n_mode = M_NUMBER;
                n_acc  = digit;
            end else if (c == CH_QUOTE) begin
                n_mode = M_STRING;
                n_tcnt = '0;
            end else if (is_alpha(c)) begin
                n_mode = M_IDENT;
                s_push = push_res(s_push, K_ICHR, {56'd0, c}, r_line);
                n_tcnt = 8'd1;
            end else if ((c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT)) begin
                n_mode = M_HELD;
                n_held = c;
            end else if (is_single_op(c)) begin
                s_push = push_res(s_push, K_OP, {56'd0, c}, r_line);
                do_td2 = 1'b1;
            end else begin
                s_push = push_res(s_push, K_ERR, {56'd0, c}, r_line);
                n_mode = M_DISCARD;
            end
        end

        // Token completed by a single-character operator.
        if (do_td2) begin
            n_tok = n_tok + 16'd1;
            if (n_tok >= MAX_TOKENS) begin
                if (s_push.count != 2'd2) begin
                    s_push = push_res(s_push, K_END, 64'd0, r_line);
                    n_mode = M_DISCARD;
                    if (c == CH_NUL) do_restart = 1'b1;
                end else begin
                    n_mode = M_ENDING;
                end
            end
        end

        // A restart is always the final action of a byte.
        if (do_restart) begin
            n_mode = M_IDLE;
            n_acc  = '0;
            n_tcnt = '0;
            n_held = '0;
            n_line = 16'd1;
            n_tok  = '0;
        end

        // Mark the final result of this byte.
        s_push.res0.last = (s_push.count == 2'd1);
        s_push.res1.last = (s_push.count == 2'd2);
    end

    assign o_push = s_push;

endmodule

// ===== rtl/stc_result_fifo.sv =====
// Four-entry result queue: takes up to two results per cycle, delivers one.
// Depends on stc_pkg for the result types and queue geometry.
module stc_result_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_en,
    input  stc_pkg::t_push  i_push,
    output logic            o_space,
    output logic            o_valid,
    input  logic            i_pop,
    output stc_pkg::t_result o_head
);
    import stc_pkg::*;

    `include "script_tokenizer_defines.svh"

    t_result                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wp,    n_wp;
    logic [FIFO_PTR_W-1:0]   r_rp,    n_rp;
    logic [FIFO_CNT_W-1:0]   r_count, n_count;
    logic [1:0]              s_push_n;
    logic                    s_pop;

    assign s_push_n = i_push_en ? i_push.count : 2'd0;
    assign s_pop    = o_valid && i_pop;
    assign o_valid  = (r_count != '0);
    assign o_space  = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_head   = r_mem[r_rp];

    // Pointer and fill count arithmetic.
    always_comb begin
        n_wp    = r_wp + FIFO_PTR_W'(s_push_n);
        n_rp    = r_rp + FIFO_PTR_W'(s_pop);
        n_count = r_count + FIFO_CNT_W'(s_push_n) - FIFO_CNT_W'(s_pop);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Result storage, written at the write pointer and the entry after it.
    always_ff @(posedge i_clk) begin
        if (s_push_n != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (s_push_n == 2'd2) begin
            r_mem[r_wp + FIFO_PTR_W'(1)] <= i_push.res1;
        end
    end

    `STC_ASSERT_NOW(a_no_overflow, 1'b1, r_count <= FIFO_CNT_W'(FIFO_DEPTH))
    `STC_ASSERT_NOW(a_push_has_room, s_push_n != 2'd0, r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2))
    `STC_ASSERT_NOW(a_single_last, s_push_n == 2'd1, i_push.res0.last)
    `STC_ASSERT_NOW(a_pair_last, s_push_n == 2'd2, !i_push.res0.last && i_push.res1.last)
    `STC_ASSERT_NEXT(a_pop_drains, s_pop && (s_push_n == 2'd0),
                     r_count == $past(r_count) - FIFO_CNT_W'(1))

endmodule

// ===== rtl/script_tokenizer.sv =====
// Script tokenizer: source bytes in, tagged token results out.
//
// Input channel: i_in_valid / o_in_ready carry one source byte (i_char_in) per
// transaction; a zero byte ends the script. Output channel: o_out_valid /
// i_out_ready carry one result (o_kind, o_value, o_line, o_last) per transaction.
// A byte yields zero, one or two results; o_last marks the final one of a byte.
// Results are written into the result queue when a byte is taken and reach the
// output once earlier queued results have gone. Throughput: one byte per cycle
// while the receiver keeps up; bytes giving two results are limited by the
// single result port draining the four-entry result queue.
// o_in_ready is high while the queue has room for two more results, so bytes are
// taken even while earlier results wait. When the receiver stalls, results stay
// queued unchanged and o_in_ready drops once the queue holds more than two.
// Reset (synchronous, active low) empties the queue and returns the lexer to idle
// at line 1 with no pending token; no clearing pass is needed.
// Depends on stc_pkg, stc_lexer and stc_result_fifo.
module script_tokenizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_kind,
    output logic signed [63:0] o_value,
    output logic [15:0]        o_line,
    output logic               o_last
);
    import stc_pkg::*;

    logic    s_take;
    logic    s_space;
    t_push   s_push;
    t_result s_head;

    // A byte is taken when the queue can absorb both possible results.
    assign o_in_ready = s_space;
    assign s_take     = i_in_valid && s_space;

    stc_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (s_take),
        .i_char  (i_char_in),
        .o_push  (s_push)
    );

    stc_result_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (s_take),
        .i_push    (s_push),
        .o_space   (s_space),
        .o_valid   (o_out_valid),
        .i_pop     (i_out_ready),
        .o_head    (s_head)
    );

    // Result fields at the head of the queue.
    assign o_kind  = s_head.kind;
    assign o_value = signed'(s_head.value);
    assign o_line  = s_head.line;
    assign o_last  = s_head.last;

endmodule
